// ----- design/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define NCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// implication checked on every rising clock edge outside reset
`define NCD_ASSERT_IMPL(label, cond, prop, msg) \
  `NCD_ASSERT(label, (cond) |-> (prop), msg)

`endif

// ----- design/ncd_pkg.sv -----
// shared types, constants and helper functions of the nmea sentence checker
package ncd_pkg;

  localparam int unsigned NUM_KINDS = 3;
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned HDR_LEN   = 6;

  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  localparam logic [1:0] KIND_GGA   = 2'd0;
  localparam logic [1:0] KIND_VTG   = 2'd1;
  localparam logic [1:0] KIND_GSV   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // every (DECIM_MULT * fresh_period)-th valid sentence of each known kind is forwarded
  localparam logic [CNT_W-1:0] DECIM_MULT = CNT_W'(5);

  localparam logic [47:0] HDR_GGA = "$GPGGA";
  localparam logic [47:0] HDR_VTG = "$GPVTG";
  localparam logic [47:0] HDR_GSV = "$GPGSV";

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_HEX1,
    PH_HEX2,
    PH_TAIL,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic busy;
    logic done;
  } res_status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic       fwd;
    logic [7:0] csum;
    logic [7:0] rsum;
  } result_t;

  // header character expected at a position for one known kind
  function automatic logic [7:0] hdr_char(input logic [1:0] kind, input logic [2:0] pos);
    logic [47:0] word;
    logic [7:0]  ch;
    case (kind)
      KIND_GGA: word = HDR_GGA;
      KIND_VTG: word = HDR_VTG;
      KIND_GSV: word = HDR_GSV;
      default:  word = '0;
    endcase
    case (pos)
      3'd0:    ch = word[47:40];
      3'd1:    ch = word[39:32];
      3'd2:    ch = word[31:24];
      3'd3:    ch = word[23:16];
      3'd4:    ch = word[15:8];
      3'd5:    ch = word[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // {good, value}; a bad digit gives value zero
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

// ----- design/nmea_sentence_checker_decimator.sv -----
// nmea 0183 sentence checker and decimator, top level
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+---------------------------
//  input    | in_valid, in_ready, rx_byte               | in_valid && in_ready
//  result   | out_valid, out_ready, sentence_kind, ...  | out_valid && out_ready
//  config   | cfg_we, cfg_wdata (fresh_period)          | cfg_we
//
// one byte per cycle while in_ready is high; a newline that ends a '$' line has its result registered;
// the output register plus a skid entry let bytes keep flowing while a result waits
// a fresh_period write holds in_ready low during the write cycle, then while the bit-serial
// remainder unit takes one counter bit per cycle to rebase the per-kind decimation residues,
// then while they are loaded
// rst is synchronous and clears line state, counters and both result entries
module nmea_sentence_checker_decimator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] sentence_kind,
  output logic       checksum_ok,
  output logic       forward,
  output logic [7:0] computed_sum,
  output logic [7:0] received_sum,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import ncd_pkg::*;

  phase_t           phase, phase_next;
  logic [7:0]       run_xor, run_xor_next;
  logic [7:0]       sum_val, sum_val_next;
  logic             sum_good, sum_good_next;
  logic [2:0]       char_pos, char_pos_next;
  logic [2:0]       hdr_match, hdr_match_next;
  logic [CNT_W-1:0] cnt [NUM_KINDS];
  logic [CNT_W-1:0] cnt_next [NUM_KINDS];
  logic [CNT_W-1:0] resid [NUM_KINDS];
  logic [CNT_W-1:0] resid_next [NUM_KINDS];
  logic [CNT_W-1:0] modulus;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] resid_inc;
  logic [CNT_W-1:0] div_rem [NUM_KINDS];
  res_status_t      div_st;
  logic [4:0]       hex;

  logic    accept;
  logic    produce;
  result_t res;
  result_t od;
  result_t sd;
  logic    ov;
  logic    sv;
  logic    pop;

  assign accept   = in_valid && in_ready;
  assign in_ready = !sv && !div_st.busy && !cfg_we;
  assign pop      = ov && out_ready;
  assign hex      = hex_digit(rx_byte);

  always_comb begin
    phase_next     = phase;
    run_xor_next   = run_xor;
    sum_val_next   = sum_val;
    sum_good_next  = sum_good;
    char_pos_next  = char_pos;
    hdr_match_next = hdr_match;
    cnt_next       = cnt;
    resid_next     = resid;
    cnt_inc        = '0;
    resid_inc      = '0;
    produce        = 1'b0;
    res.kind       = KIND_OTHER;
    res.ok         = 1'b0;
    res.fwd        = 1'b0;
    res.csum       = run_xor;
    res.rsum       = sum_val;

    if (accept) begin
      if (rx_byte == CH_NEWLINE) begin
        phase_next = PH_IDLE;
        if (phase == PH_BODY || phase == PH_HEX1 || phase == PH_HEX2 ||
            phase == PH_TAIL) begin
          produce = 1'b1;
          if (char_pos >= 3'(HDR_LEN)) begin
            if (hdr_match[0]) begin
              res.kind = KIND_GGA;
            end else if (hdr_match[1]) begin
              res.kind = KIND_VTG;
            end else if (hdr_match[2]) begin
              res.kind = KIND_GSV;
            end
          end
          res.ok = (phase == PH_TAIL) && sum_good && (sum_val == run_xor);
          if (res.ok && res.kind != KIND_OTHER) begin
            for (int k = 0; k < NUM_KINDS; k++) begin
              if (res.kind == 2'(k)) begin
                cnt_inc   = cnt[k] + 1'b1;
                resid_inc = resid[k] + 1'b1;
                cnt_next[k] = cnt_inc;
                // a wrap to zero is forwarded as well
                if (cnt_inc == '0 || resid_inc == modulus) begin
                  resid_next[k] = '0;
                  res.fwd       = 1'b1;
                end else begin
                  resid_next[k] = resid_inc;
                end
              end
            end
          end
        end
      end else if (phase == PH_IDLE) begin
        if (rx_byte == CH_DOLLAR) begin
          phase_next     = PH_BODY;
          run_xor_next   = '0;
          sum_val_next   = '0;
          sum_good_next  = 1'b0;
          char_pos_next  = 3'd1;
          hdr_match_next = '1;
        end else begin
          phase_next = PH_SKIP;
        end
      end else if (phase != PH_SKIP) begin
        if (char_pos < 3'(HDR_LEN)) begin
          for (int k = 0; k < NUM_KINDS; k++) begin
            if (hdr_char(2'(k), char_pos) != rx_byte) begin
              hdr_match_next[k] = 1'b0;
            end
          end
          char_pos_next = char_pos + 1'b1;
        end
        case (phase)
          PH_BODY: begin
            if (rx_byte == CH_STAR) begin
              sum_good_next = 1'b1;
              phase_next    = PH_HEX1;
            end else begin
              run_xor_next = run_xor ^ rx_byte;
            end
          end
          PH_HEX1: begin
            sum_val_next  = {sum_val[3:0], hex[3:0]};
            sum_good_next = sum_good & hex[4];
            phase_next    = PH_HEX2;
          end
          PH_HEX2: begin
            sum_val_next  = {sum_val[3:0], hex[3:0]};
            sum_good_next = sum_good & hex[4];
            phase_next    = PH_TAIL;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      run_xor   <= '0;
      sum_val   <= '0;
      sum_good  <= 1'b0;
      char_pos  <= '0;
      hdr_match <= '1;
      modulus   <= DECIM_MULT;
      for (int k = 0; k < NUM_KINDS; k++) begin
        cnt[k]   <= '0;
        resid[k] <= '0;
      end
    end else begin
      phase     <= phase_next;
      run_xor   <= run_xor_next;
      sum_val   <= sum_val_next;
      sum_good  <= sum_good_next;
      char_pos  <= char_pos_next;
      hdr_match <= hdr_match_next;
      cnt       <= cnt_next;
      if (cfg_we) begin
        // a period of zero acts as one
        if (cfg_wdata == 8'd0) begin
          modulus <= DECIM_MULT;
        end else begin
          modulus <= CNT_W'({cfg_wdata, 2'b00}) + CNT_W'(cfg_wdata);
        end
      end
      if (div_st.done) begin
        resid <= div_rem;
      end else begin
        resid <= resid_next;
      end
    end
  end

  ncd_residue u_residue (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .cnt     (cnt),
    .modulus (modulus),
    .status  (div_st),
    .rem     (div_rem)
  );

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (pop) begin
      if (sv) begin
        sv <= 1'b0;
      end else if (!produce) begin
        ov <= 1'b0;
      end
    end else if (produce) begin
      if (!ov) begin
        ov <= 1'b1;
      end else begin
        sv <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (sv) begin
        od <= sd;
      end else if (produce) begin
        od <= res;
      end
    end else if (produce) begin
      if (!ov) begin
        od <= res;
      end else begin
        sd <= res;
      end
    end
  end

  assign out_valid     = ov;
  assign sentence_kind = od.kind;
  assign checksum_ok   = od.ok;
  assign forward       = od.fwd;
  assign computed_sum  = od.csum;
  assign received_sum  = od.rsum;

endmodule

// ----- design/ncd_residue.sv -----
// bit-serial remainder unit: recomputes each kind counter modulo the decimation count
module ncd_residue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ncd_pkg::CNT_W-1:0]  cnt [ncd_pkg::NUM_KINDS],
  input  logic [ncd_pkg::CNT_W-1:0]  modulus,
  output ncd_pkg::res_status_t       status,
  output logic [ncd_pkg::CNT_W-1:0]  rem [ncd_pkg::NUM_KINDS]
);
  import ncd_pkg::*;

  localparam int unsigned IDX_W = $clog2(CNT_W);

  logic             running;
  logic             done;
  logic [IDX_W-1:0] idx;
  logic [CNT_W:0]   trial [NUM_KINDS];
  logic [CNT_W-1:0] rem_next [NUM_KINDS];

  // one restoring step per cycle while running, msb first, all kinds side by side
  always_comb begin
    for (int k = 0; k < NUM_KINDS; k++) begin
      trial[k] = {rem[k], cnt[k][idx]};
      if (trial[k] >= {1'b0, modulus}) begin
        rem_next[k] = CNT_W'(trial[k] - {1'b0, modulus});
      end else begin
        rem_next[k] = trial[k][CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      idx     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      idx     <= IDX_W'(CNT_W - 1);
    end else begin
      done <= running && (idx == '0);
      if (running) begin
        if (idx == '0) begin
          running <= 1'b0;
        end else begin
          idx <= idx - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_KINDS; k++) begin
      if (start) begin
        rem[k] <= '0;
      end else if (running) begin
        rem[k] <= rem_next[k];
      end
    end
  end

  // busy covers the cycle in which the caller loads the remainders
  assign status.busy = running | done;
  assign status.done = done;

endmodule

// ----- design/ncd_checker.sv -----
// port-level checks of the nmea sentence checker, bound to the top level
`include "assert_macros.svh"

module ncd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] sentence_kind,
  input logic       checksum_ok,
  input logic       forward,
  input logic [7:0] computed_sum,
  input logic [7:0] received_sum,
  input logic       cfg_we
);
  import ncd_pkg::*;

  logic [19:0] payload;
  logic        stalled;
  logic        known_ok;
  logic        sums_eq;
  logic        nl_taken;

  assign payload  = {sentence_kind, checksum_ok, forward, computed_sum, received_sum};
  assign stalled  = out_valid && !out_ready;
  assign known_ok = checksum_ok && (sentence_kind != KIND_OTHER);
  assign sums_eq  = (computed_sum == received_sum);
  assign nl_taken = in_valid && in_ready && (rx_byte == CH_NEWLINE);

  // a stalled result keeps its place and its value
  `NCD_ASSERT_IMPL(a_out_hold, stalled, ##1 (out_valid && $stable(payload)), "stalled result changed")

  // only a valid sentence of a known kind is forwarded
  `NCD_ASSERT_IMPL(a_fwd_valid, out_valid && forward, known_ok, "forward on a bad or unknown line")

  // a passing check means both sums agree
  `NCD_ASSERT_IMPL(a_ok_sums, out_valid && checksum_ok, sums_eq, "checksum_ok with unequal sums")

  // a new result appears only after a newline transfer
  `NCD_ASSERT_IMPL(a_rise_newline, $rose(out_valid), $past(nl_taken), "result without a newline")

  // no byte is taken during a configuration write
  `NCD_ASSERT_IMPL(a_cfg_block, cfg_we, !in_ready, "byte taken during a config write")

endmodule

bind nmea_sentence_checker_decimator ncd_checker u_ncd_checker (.*);

// ----- tb/sentence_result_checker.sv -----
// result checker for the nmea sentence checker: predicts each line report and compares it
`timescale 1ns / 1ps

module sentence_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  sentence_kind,
  input  logic        checksum_ok,
  input  logic        forward,
  input  logic [7:0]  computed_sum,
  input  logic [7:0]  received_sum,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        wrap_up,
  output int unsigned mismatches,
  output int unsigned results_owed
);
  import ncd_pkg::*;

  phase_t           line_st = PH_IDLE;
  logic [7:0]       xor_acc = '0;
  logic [7:0]       sum_acc = '0;
  logic             digits_good = 1'b0;
  logic [2:0]       hdr_pos = '0;
  logic [2:0]       hdr_hit = '1;
  logic [CNT_W-1:0] valid_count [NUM_KINDS];
  logic [7:0]       period_reg = 8'd1;
  result_t          pending_reports [$];
  int unsigned      fail_tally = 0;
  bit               wrap_done = 1'b0;
  result_t          got;
  result_t          want;
  result_t          fresh;

  assign mismatches = fail_tally;

  function automatic logic [47:0] header_word(input int k);
    case (k)
      0:       return HDR_GGA;
      1:       return HDR_VTG;
      default: return HDR_GSV;
    endcase
  endfunction

  // -1 marks a byte that is not a hex digit
  function automatic int digit_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic void take_digit(input logic [7:0] c);
    int d;
    d = digit_value(c);
    if (d < 0) begin
      digits_good = 1'b0;
      d = 0;
    end
    sum_acc = {sum_acc[3:0], 4'(d)};
  endfunction

  // moves the line state by one byte; returns 1 when the byte closes a reported line
  function automatic bit absorb_byte(input logic [7:0] c, output result_t rep);
    logic [1:0]  kind;
    logic        ok;
    logic        fwd;
    logic [7:0]  ch;
    int          span;
    rep = '0;
    if (c == CH_NEWLINE) begin
      if (line_st inside {PH_BODY, PH_HEX1, PH_HEX2, PH_TAIL}) begin
        kind = KIND_OTHER;
        if (hdr_pos >= HDR_LEN) begin
          for (int k = int'(NUM_KINDS) - 1; k >= 0; k--) begin
            if (hdr_hit[k]) kind = 2'(k);
          end
        end
        ok = (line_st == PH_TAIL) && digits_good && (sum_acc == xor_acc);
        fwd = 1'b0;
        if (ok && kind != KIND_OTHER) begin
          valid_count[kind] = valid_count[kind] + 1'b1;
          span = int'(DECIM_MULT) * ((period_reg == 8'd0) ? 1 : int'(period_reg));
          fwd = (int'(valid_count[kind]) % span) == 0;
        end
        rep.kind = kind;
        rep.ok   = ok;
        rep.fwd  = fwd;
        rep.csum = xor_acc;
        rep.rsum = sum_acc;
        line_st = PH_IDLE;
        return 1'b1;
      end
      line_st = PH_IDLE;
      return 1'b0;
    end
    if (line_st == PH_IDLE) begin
      if (c == CH_DOLLAR) begin
        line_st     = PH_BODY;
        xor_acc     = '0;
        sum_acc     = '0;
        digits_good = 1'b0;
        hdr_pos     = 3'd1;
        hdr_hit     = '1;
      end else begin
        line_st = PH_SKIP;
      end
      return 1'b0;
    end
    if (line_st == PH_SKIP) return 1'b0;
    if (hdr_pos < HDR_LEN) begin
      for (int k = 0; k < int'(NUM_KINDS); k++) begin
        ch = 8'(header_word(k) >> (8 * (int'(HDR_LEN) - 1 - int'(hdr_pos))));
        if (ch != c) hdr_hit[k] = 1'b0;
      end
      hdr_pos = hdr_pos + 1'b1;
    end
    case (line_st)
      PH_BODY: begin
        if (c == CH_STAR) begin
          digits_good = 1'b1;
          line_st = PH_HEX1;
        end else begin
          xor_acc = xor_acc ^ c;
        end
      end
      PH_HEX1: begin
        take_digit(c);
        line_st = PH_HEX2;
      end
      PH_HEX2: begin
        take_digit(c);
        line_st = PH_TAIL;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic compare_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_st     = PH_IDLE;
      xor_acc     = '0;
      sum_acc     = '0;
      digits_good = 1'b0;
      hdr_pos     = '0;
      hdr_hit     = '1;
      period_reg  = 8'd1;
      foreach (valid_count[k]) valid_count[k] = '0;
      pending_reports.delete();
    end else begin
      if (cfg_we) period_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        if (absorb_byte(rx_byte, fresh)) pending_reports.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        got.kind = sentence_kind;
        got.ok   = checksum_ok;
        got.fwd  = forward;
        got.csum = computed_sum;
        got.rsum = received_sum;
        if (pending_reports.size() == 0) begin
          $error("line report with no line pending: kind %0d sum %0d", got.kind, got.csum);
          fail_tally++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("sentence_kind", want.kind, got.kind);
          compare_field("checksum_ok", want.ok, got.ok);
          compare_field("forward", want.fwd, got.fwd);
          compare_field("computed_sum", want.csum, got.csum);
          compare_field("received_sum", want.rsum, got.rsum);
        end
      end
      if (wrap_up && !wrap_done) begin
        wrap_done = 1'b1;
        if (pending_reports.size() != 0) begin
          $error("%0d line reports never arrived", pending_reports.size());
          fail_tally++;
        end
      end
    end
    results_owed <= pending_reports.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// testbench top: clock, reset, stimulus, idling, stalls, period writes, watchdog, verdict
`timescale 1ns / 1ps

module tb_top;
  import ncd_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BURST_LINES    = 30;

  typedef enum int {
    LM_GOOD,
    LM_WRONG,
    LM_ONE_DIGIT,
    LM_BAD_DIGIT,
    LM_NO_STAR,
    LM_NO_DIGIT
  } frame_form_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  sentence_kind;
  logic        checksum_ok;
  logic        forward;
  logic [7:0]  computed_sum;
  logic [7:0]  received_sum;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;
  logic        wrap_up = 1'b0;
  int unsigned mismatches;
  int unsigned results_owed;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;
  logic [7:0]  line_buf [$];

  nmea_sentence_checker_decimator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sentence_kind (sentence_kind),
    .checksum_ok   (checksum_ok),
    .forward       (forward),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  sentence_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sentence_kind (sentence_kind),
    .checksum_ok   (checksum_ok),
    .forward       (forward),
    .computed_sum  (computed_sum),
    .received_sum  (received_sum),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .wrap_up       (wrap_up),
    .mismatches    (mismatches),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] c;
    do c = 8'($urandom); while (c == CH_NEWLINE || is_hex(c));
    return c;
  endfunction

  function automatic logic [7:0] body_byte(input bit wide);
    logic [7:0] c;
    do c = wide ? 8'($urandom) : 8'($urandom_range(32, 126));
    while (c == CH_NEWLINE || c == CH_STAR);
    return c;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    line_buf.push_back(b);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // mostly the three known headers, else near misses, random text or short ones
  function automatic string pick_header();
    string s;
    case ($urandom_range(9))
      0, 1, 2: s = "GPGGA";
      3, 4:    s = "GPVTG";
      5, 6:    s = "GPGSV";
      7: begin
        s = ($urandom_range(1) == 0) ? "GPGGA" : "GPGSV";
        s[$urandom_range(4)] = 8'($urandom_range(65, 90));
      end
      8: begin
        s = "XXXXX";
        for (int i = 0; i < 5; i++) s[i] = body_byte(1'b0);
      end
      default: begin
        case ($urandom_range(2))
          0:       s = "";
          1:       s = "G";
          default: s = "GPGG";
        endcase
      end
    endcase
    return s;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) push_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic send_sentence(input string hdr, input int body_len, input frame_form_t form,
                               input bit lower, input bit tail);
    logic [7:0] acc;
    logic [7:0] c;
    acc = '0;
    add_byte(CH_DOLLAR);
    for (int i = 0; i < hdr.len(); i++) begin
      add_byte(hdr[i]);
      acc = acc ^ hdr[i];
    end
    for (int i = 0; i < body_len; i++) begin
      c = body_byte(form != LM_GOOD);
      add_byte(c);
      acc = acc ^ c;
    end
    case (form)
      LM_GOOD, LM_WRONG: begin
        if (form == LM_WRONG) acc = acc ^ 8'($urandom_range(1, 255));
        add_byte(CH_STAR);
        add_byte(hex_char(acc[7:4], lower));
        add_byte(hex_char(acc[3:0], lower));
      end
      LM_ONE_DIGIT: begin
        add_byte(CH_STAR);
        add_byte(hex_char(acc[7:4], lower));
      end
      LM_BAD_DIGIT: begin
        add_byte(CH_STAR);
        if ($urandom_range(1) == 0) begin
          add_byte(non_hex_byte());
          add_byte(hex_char(acc[3:0], lower));
        end else begin
          add_byte(hex_char(acc[7:4], lower));
          add_byte(non_hex_byte());
        end
      end
      LM_NO_DIGIT: add_byte(CH_STAR);
      default: ;
    endcase
    if (tail) add_byte(($urandom_range(1) == 0) ? 8'h0D : body_byte(1'b1));
    add_byte(CH_NEWLINE);
    send_line();
  endtask

  task automatic send_noise_line();
    int         len;
    logic [7:0] c;
    len = $urandom_range(0, 12);
    if ($urandom_range(1) == 1) add_byte(CH_DOLLAR);
    repeat (len) begin
      case ($urandom_range(3))
        0:       c = CH_STAR;
        1:       c = hex_char(4'($urandom), 1'($urandom_range(1)));
        default: do c = 8'($urandom); while (c == CH_NEWLINE);
      endcase
      add_byte(c);
    end
    add_byte(CH_NEWLINE);
    send_line();
  endtask

  task automatic send_random_line();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) begin
      send_sentence(pick_header(), $urandom_range(0, 6),
                    ($urandom_range(9) == 0) ? LM_WRONG : LM_GOOD,
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if (pick < 88) begin
      send_sentence(pick_header(), $urandom_range(0, 6),
                    frame_form_t'($urandom_range(LM_WRONG, LM_NO_DIGIT)),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
    end else begin
      send_noise_line();
    end
  endtask

  task automatic run_traffic(input int unsigned goal);
    int unsigned stop_at;
    stop_at = bytes_sent + goal;
    while (bytes_sent < stop_at) send_random_line();
  endtask

  // stop sending, let every owed report out, then give the block time to settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [7:0] period, input int unsigned idle,
                           input int unsigned stall, input int unsigned goal,
                           input bit hold_off);
    drain_and_settle();
    write_period(period);
    idle_pct  = idle;
    stall_pct = stall;
    run_traffic(goal / 2);
    if (hold_off) drain_and_settle();
    run_traffic(goal / 2);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed lines at the reset period
    add_byte(CH_NEWLINE);
    send_line();
    add_text("GPGGA");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(CH_NEWLINE);
    send_line();
    send_sentence("GPGGA", 0, LM_GOOD, 1'b0, 1'b1);
    send_sentence("GPVTG", 2, LM_GOOD, 1'b1, 1'b0);
    send_sentence("GPGSV", 0, LM_WRONG, 1'b0, 1'b0);
    send_sentence("GPRMC", 0, LM_GOOD, 1'b0, 1'b0);
    send_sentence("GP", 0, LM_GOOD, 1'b0, 1'b0);
    send_sentence("", 0, LM_NO_STAR, 1'b0, 1'b0);
    send_sentence("GPGGA", 1, LM_NO_STAR, 1'b0, 1'b0);
    send_sentence("GPGGA", 0, LM_ONE_DIGIT, 1'b0, 1'b0);
    send_sentence("GPGGA", 0, LM_BAD_DIGIT, 1'b0, 1'b0);
    send_sentence("GPGGA", 0, LM_NO_DIGIT, 1'b0, 1'b0);
    // four more good ones make the fifth and raise forward
    repeat (4) send_sentence("GPGGA", 0, LM_GOOD, 1'b1, 1'b0);

    run_phase(8'd0, 0, 0, 200, 1'b0);
    run_phase(8'd255, 50, 0, 200, 1'b0);
    run_phase(8'd2, 0, 50, 200, 1'b1);
    run_phase(8'd1, 8, 8, 200, 1'b0);

    // burst of one kind after a period change rebases its residue
    drain_and_settle();
    write_period(8'd3);
    idle_pct  = 0;
    stall_pct = 0;
    repeat (BURST_LINES) send_sentence("GPGGA", 0, LM_GOOD, 1'($urandom_range(1)), 1'b0);

    drain_and_settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
